// ===== rtl/core/ttblc_pkg.sv =====
// ----------------------------------------------------------------------------
// ttblc_pkg
// Shared types, codes and defaults of the two-tier budgeted LRU cache.
// ----------------------------------------------------------------------------
package ttblc_pkg;

	localparam int ENTRIES_DEF = 16;
	localparam int BUDGET_W    = 40;
	localparam int KEY_W       = 32;
	localparam int SIZE_W      = 32;

	localparam logic [BUDGET_W-1:0] FAST_BUDGET_RST = 40'd536870912;
	localparam logic [BUDGET_W-1:0] SLOW_BUDGET_RST = 40'd4294967295;

	// Request operations.
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	// Configuration register indexes.
	localparam logic [1:0] REG_FAST_BUDGET = 2'd0;
	localparam logic [1:0] REG_SLOW_BUDGET = 2'd1;

	// Result event codes.
	localparam logic [3:0] EV_FAST_HIT   = 4'd0;
	localparam logic [3:0] EV_RELOADED   = 4'd1;
	localparam logic [3:0] EV_MISS       = 4'd2;
	localparam logic [3:0] EV_RELOAD_BAD = 4'd3;
	localparam logic [3:0] EV_INSERTED   = 4'd4;
	localparam logic [3:0] EV_TOO_LARGE  = 4'd5;
	localparam logic [3:0] EV_DEMOTED    = 4'd6;
	localparam logic [3:0] EV_DROPPED    = 4'd7;
	localparam logic [3:0] EV_SLOW_DEL   = 4'd8;

	// Slot tier marks.
	localparam logic [1:0] TIER_EMPTY = 2'd0;
	localparam logic [1:0] TIER_FAST  = 2'd1;
	localparam logic [1:0] TIER_SLOW  = 2'd2;

	// LRU list operations.
	localparam logic [2:0] LOP_NONE   = 3'd0;
	localparam logic [2:0] LOP_PUSH   = 3'd1;
	localparam logic [2:0] LOP_REMOVE = 3'd2;
	localparam logic [2:0] LOP_FRONT  = 3'd3;
	localparam logic [2:0] LOP_POP    = 3'd4;

	typedef struct packed {
		logic              op;
		logic [KEY_W-1:0]  key;
		logic [SIZE_W-1:0] entry_size;
		logic              keep_slow;
		logic              reload_ok;
	} req_t;

	typedef struct packed {
		logic [3:0]        event_res;
		logic [KEY_W-1:0]  event_key;
		logic [SIZE_W-1:0] event_size;
		logic              last;
	} res_t;

endpackage

// ===== rtl/core/two_tier_budget_lru_cache.sv =====
// ----------------------------------------------------------------------------
// two_tier_budget_lru_cache
// Fast and slow LRU tiers under byte budgets over one shared slot table.
// ----------------------------------------------------------------------------
//  Channel   Signals                                   Direction
//  request   start, busy, req                          in (busy out)
//  result    res_valid, res                            out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data in (ready out)
//
// A request scans the slot table one slot a cycle through the single read
// port of the entry RAM, then takes a decision step. Lookups without reload
// end there; a reload and every insert go on to trim the tiers, and an insert
// into a full table first evicts one entry. Too-large inserts skip the scan.
// The final result shows in the first idle cycle; results cannot be stalled.
// Reset clears all tiers and counts and loads the default budgets.
module two_tier_budget_lru_cache #(
	parameter int ENTRIES = ttblc_pkg::ENTRIES_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  ttblc_pkg::req_t      req,
	output logic                 res_valid,
	output ttblc_pkg::res_t      res,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [ttblc_pkg::BUDGET_W-1:0] cfg_data
);
	import ttblc_pkg::*;

	localparam int SW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_SCAN    = 4'd1;
	localparam logic [3:0] ST_DECIDE  = 4'd2;
	localparam logic [3:0] ST_EVICT   = 4'd3;
	localparam logic [3:0] ST_PLACE   = 4'd4;
	localparam logic [3:0] ST_TRIM_F  = 4'd5;
	localparam logic [3:0] ST_TRIM_FW = 4'd6;
	localparam logic [3:0] ST_TRIM_S  = 4'd7;
	localparam logic [3:0] ST_TRIM_SW = 4'd8;
	localparam logic [3:0] ST_FINISH  = 4'd9;

	logic [3:0]          state_q;
	req_t                req_q;
	logic [CW-1:0]       scan_q;
	logic [CW-1:0]       scan_m1;
	logic [SW-1:0]       scan_e;
	logic                found_q;
	logic [SW-1:0]       found_idx_q;
	logic [SIZE_W-1:0]   found_size_q;
	logic                free_v_q;
	logic [SW-1:0]       free_idx_q;
	logic [SW-1:0]       slot_q;
	logic [SW-1:0]       vic_q;
	logic                vic_slow_q;
	logic [BUDGET_W-1:0] fast_used_q;
	logic [BUDGET_W-1:0] slow_used_q;
	logic [BUDGET_W-1:0] fast_budget_q;
	logic [BUDGET_W-1:0] slow_budget_q;
	logic [1:0]          tier_q [ENTRIES];
	logic                keep_q [ENTRIES];
	logic                pend_v_q;
	res_t                pend_q;
	res_t                res_q;
	logic                res_valid_q;

	logic [2:0]          f_op;
	logic [SW-1:0]       f_slot;
	logic [CW-1:0]       f_cnt;
	logic [SW-1:0]       f_oldest;
	logic [2:0]          s_op;
	logic [SW-1:0]       s_slot;
	logic [CW-1:0]       s_cnt;
	logic [SW-1:0]       s_oldest;

	logic                ram_we;
	logic [SW-1:0]       ram_raddr;
	logic [63:0]         ram_rdata;
	logic [KEY_W-1:0]    rd_key;
	logic [SIZE_W-1:0]   rd_size;

	logic                emit_v;
	logic [3:0]          emit_ev;
	logic [KEY_W-1:0]    emit_key;
	logic [SIZE_W-1:0]   emit_size;

	logic                too_large;
	logic                f_over;
	logic                s_over;
	logic                scan_hit;

	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = !busy;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	assign scan_m1   = scan_q - 1'b1;
	assign scan_e    = scan_m1[SW-1:0];
	assign rd_key    = ram_rdata[63:32];
	assign rd_size   = ram_rdata[31:0];
	assign too_large = {8'd0, req.entry_size} > fast_budget_q;
	assign f_over    = (fast_used_q > fast_budget_q) && (f_cnt != '0);
	assign s_over    = (slow_used_q > slow_budget_q) && (s_cnt != '0);
	assign scan_hit  = (tier_q[scan_e] != TIER_EMPTY) && (rd_key == req_q.key);

	ttblc_ram #(
		.WIDTH (64),
		.DEPTH (ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (slot_q),
		.wdata ({req_q.key, req_q.entry_size}),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	ttblc_list #(.ENTRIES(ENTRIES)) u_fast (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (f_op),
		.slot   (f_slot),
		.count  (f_cnt),
		.oldest (f_oldest)
	);

	ttblc_list #(.ENTRIES(ENTRIES)) u_slow (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (s_op),
		.slot   (s_slot),
		.count  (s_cnt),
		.oldest (s_oldest)
	);

	always_comb begin
		f_op      = LOP_NONE;
		f_slot    = found_idx_q;
		s_op      = LOP_NONE;
		s_slot    = found_idx_q;
		ram_we    = 1'b0;
		ram_raddr = scan_q[SW-1:0];
		emit_v    = 1'b0;
		emit_ev   = EV_MISS;
		emit_key  = req_q.key;
		emit_size = rd_size;
		unique case (state_q)
			ST_IDLE: begin
				if (start && (req.op == OP_INSERT) && too_large) begin
					emit_v    = 1'b1;
					emit_ev   = EV_TOO_LARGE;
					emit_key  = req.key;
					emit_size = req.entry_size;
				end
			end
			ST_SCAN: begin
			end
			ST_DECIDE: begin
				if (req_q.op == OP_LOOKUP) begin
					emit_v    = 1'b1;
					emit_size = found_size_q;
					if (!found_q) begin
						emit_ev   = EV_MISS;
						emit_size = '0;
					end else if (tier_q[found_idx_q] == TIER_FAST) begin
						f_op    = LOP_FRONT;
						emit_ev = EV_FAST_HIT;
					end else begin
						s_op = LOP_REMOVE;
						if (req_q.reload_ok) begin
							f_op    = LOP_PUSH;
							emit_ev = EV_RELOADED;
						end else begin
							emit_ev = EV_RELOAD_BAD;
						end
					end
				end else if (found_q) begin
					if (tier_q[found_idx_q] == TIER_FAST) begin
						f_op = LOP_REMOVE;
					end else begin
						s_op = LOP_REMOVE;
					end
				end else if (!free_v_q) begin
					// Table full: the oldest slow entry goes first, else the oldest fast.
					if (s_cnt != '0) begin
						s_op      = LOP_POP;
						ram_raddr = s_oldest;
					end else begin
						f_op      = LOP_POP;
						ram_raddr = f_oldest;
					end
				end
			end
			ST_EVICT: begin
				emit_v   = 1'b1;
				emit_ev  = vic_slow_q ? EV_SLOW_DEL : EV_DROPPED;
				emit_key = rd_key;
			end
			ST_PLACE: begin
				ram_we    = 1'b1;
				f_op      = LOP_PUSH;
				f_slot    = slot_q;
				emit_v    = 1'b1;
				emit_ev   = EV_INSERTED;
				emit_size = req_q.entry_size;
			end
			ST_TRIM_F: begin
				if (f_over) begin
					f_op      = LOP_POP;
					ram_raddr = f_oldest;
				end
			end
			ST_TRIM_FW: begin
				emit_v   = 1'b1;
				emit_key = rd_key;
				if (keep_q[vic_q]) begin
					emit_ev = EV_DEMOTED;
					s_op    = LOP_PUSH;
					s_slot  = vic_q;
				end else begin
					emit_ev = EV_DROPPED;
				end
			end
			ST_TRIM_S: begin
				if (s_over) begin
					s_op      = LOP_POP;
					ram_raddr = s_oldest;
				end
			end
			ST_TRIM_SW: begin
				emit_v   = 1'b1;
				emit_ev  = EV_SLOW_DEL;
				emit_key = rd_key;
			end
			ST_FINISH: begin
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			req_q         <= '0;
			scan_q        <= '0;
			found_q       <= 1'b0;
			found_idx_q   <= '0;
			found_size_q  <= '0;
			free_v_q      <= 1'b0;
			free_idx_q    <= '0;
			slot_q        <= '0;
			vic_q         <= '0;
			vic_slow_q    <= 1'b0;
			fast_used_q   <= '0;
			slow_used_q   <= '0;
			fast_budget_q <= FAST_BUDGET_RST;
			slow_budget_q <= SLOW_BUDGET_RST;
			for (int i = 0; i < ENTRIES; i++) begin
				tier_q[i] <= TIER_EMPTY;
				keep_q[i] <= 1'b0;
			end
			pend_v_q      <= 1'b0;
			pend_q        <= '0;
			res_q         <= '0;
			res_valid_q   <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FAST_BUDGET: fast_budget_q <= cfg_data;
					REG_SLOW_BUDGET: slow_budget_q <= cfg_data;
					default: begin
					end
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q    <= req;
						scan_q   <= '0;
						found_q  <= 1'b0;
						free_v_q <= 1'b0;
						if ((req.op == OP_INSERT) && too_large) begin
							state_q <= ST_FINISH;
						end else begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_SCAN: begin
					scan_q <= scan_q + 1'b1;
					if (scan_q != '0) begin
						if (scan_hit && !found_q) begin
							found_q      <= 1'b1;
							found_idx_q  <= scan_e;
							found_size_q <= rd_size;
						end
						if ((tier_q[scan_e] == TIER_EMPTY) && !free_v_q) begin
							free_v_q   <= 1'b1;
							free_idx_q <= scan_e;
						end
					end
					if (scan_q == CW'(ENTRIES)) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					if (req_q.op == OP_LOOKUP) begin
						if (found_q && (tier_q[found_idx_q] != TIER_FAST)) begin
							slow_used_q <= slow_used_q - {8'd0, found_size_q};
							if (req_q.reload_ok) begin
								tier_q[found_idx_q] <= TIER_FAST;
								fast_used_q <= fast_used_q + {8'd0, found_size_q};
								state_q     <= ST_TRIM_F;
							end else begin
								tier_q[found_idx_q] <= TIER_EMPTY;
								state_q             <= ST_FINISH;
							end
						end else begin
							state_q <= ST_FINISH;
						end
					end else if (found_q) begin
						// The old copy's slot frees up; the lowest free slot is taken.
						if (tier_q[found_idx_q] == TIER_FAST) begin
							fast_used_q <= fast_used_q - {8'd0, found_size_q};
						end else begin
							slow_used_q <= slow_used_q - {8'd0, found_size_q};
						end
						tier_q[found_idx_q] <= TIER_EMPTY;
						if (free_v_q && (free_idx_q < found_idx_q)) begin
							slot_q <= free_idx_q;
						end else begin
							slot_q <= found_idx_q;
						end
						state_q <= ST_PLACE;
					end else if (free_v_q) begin
						slot_q  <= free_idx_q;
						state_q <= ST_PLACE;
					end else begin
						vic_slow_q <= (s_cnt != '0);
						vic_q      <= (s_cnt != '0) ? s_oldest : f_oldest;
						state_q    <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					if (vic_slow_q) begin
						slow_used_q <= slow_used_q - {8'd0, rd_size};
					end else begin
						fast_used_q <= fast_used_q - {8'd0, rd_size};
					end
					tier_q[vic_q] <= TIER_EMPTY;
					slot_q        <= vic_q;
					state_q       <= ST_PLACE;
				end
				ST_PLACE: begin
					tier_q[slot_q] <= TIER_FAST;
					keep_q[slot_q] <= req_q.keep_slow;
					fast_used_q    <= fast_used_q + {8'd0, req_q.entry_size};
					state_q        <= ST_TRIM_F;
				end
				ST_TRIM_F: begin
					if (f_over) begin
						vic_q   <= f_oldest;
						state_q <= ST_TRIM_FW;
					end else begin
						state_q <= ST_TRIM_S;
					end
				end
				ST_TRIM_FW: begin
					fast_used_q <= fast_used_q - {8'd0, rd_size};
					if (keep_q[vic_q]) begin
						tier_q[vic_q] <= TIER_SLOW;
						slow_used_q   <= slow_used_q + {8'd0, rd_size};
					end else begin
						tier_q[vic_q] <= TIER_EMPTY;
					end
					state_q <= ST_TRIM_F;
				end
				ST_TRIM_S: begin
					if (s_over) begin
						vic_q   <= s_oldest;
						state_q <= ST_TRIM_SW;
					end else begin
						state_q <= ST_FINISH;
					end
				end
				ST_TRIM_SW: begin
					slow_used_q   <= slow_used_q - {8'd0, rd_size};
					tier_q[vic_q] <= TIER_EMPTY;
					state_q       <= ST_TRIM_S;
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Each result is held in a pending register until the next one comes, so that the final one can carry last.
			res_valid_q <= (emit_v && pend_v_q) || (state_q == ST_FINISH);
			if (state_q == ST_FINISH) begin
				res_q    <= {pend_q.event_res, pend_q.event_key, pend_q.event_size, 1'b1};
				pend_v_q <= 1'b0;
			end else if (emit_v) begin
				if (pend_v_q) begin
					res_q <= pend_q;
				end
				pend_q   <= {emit_ev, emit_key, emit_size, 1'b0};
				pend_v_q <= 1'b1;
			end
		end
	end
endmodule

// ===== rtl/core/ttblc_ram.sv =====
// ----------------------------------------------------------------------------
// ttblc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ttblc_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

// ===== rtl/core/ttblc_list.sv =====
// ----------------------------------------------------------------------------
// ttblc_list
// LRU order list of slot numbers, newest at position zero, with a count.
// ----------------------------------------------------------------------------
module ttblc_list #(
	parameter int ENTRIES = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [2:0]                   op,
	input  logic [$clog2(ENTRIES)-1:0]   slot,
	output logic [$clog2(ENTRIES+1)-1:0] count,
	output logic [$clog2(ENTRIES)-1:0]   oldest
);
	import ttblc_pkg::*;

	localparam int SW = $clog2(ENTRIES);
	localparam int CW = $clog2(ENTRIES + 1);

	logic [SW-1:0]      ord_q [ENTRIES];
	logic [SW-1:0]      ord_d [ENTRIES];
	logic [CW-1:0]      cnt_q;
	logic [CW-1:0]      cnt_d;
	logic [CW-1:0]      cnt_m1;
	logic [ENTRIES-1:0] hit;
	logic [ENTRIES-1:0] ge;

	assign cnt_m1 = cnt_q - 1'b1;
	assign count  = cnt_q;
	assign oldest = ord_q[cnt_m1[SW-1:0]];

	// ge marks every position at or behind the matching one.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			hit[i] = (ord_q[i] == slot) && (CW'(i) < cnt_q);
		end
		ge[0] = hit[0];
		for (int i = 1; i < ENTRIES; i++) begin
			ge[i] = ge[i-1] | hit[i];
		end
	end

	always_comb begin
		ord_d = ord_q;
		cnt_d = cnt_q;
		unique case (op)
			LOP_PUSH: begin
				if (cnt_q < CW'(ENTRIES)) begin
					ord_d[0] = slot;
					for (int i = 1; i < ENTRIES; i++) begin
						ord_d[i] = ord_q[i-1];
					end
					cnt_d = cnt_q + 1'b1;
				end
			end
			LOP_REMOVE: begin
				for (int i = 0; i < ENTRIES - 1; i++) begin
					if (ge[i]) begin
						ord_d[i] = ord_q[i+1];
					end
				end
				if (|hit) begin
					cnt_d = cnt_m1;
				end
			end
			LOP_FRONT: begin
				ord_d[0] = slot;
				for (int i = 1; i < ENTRIES; i++) begin
					if (!ge[i-1]) begin
						ord_d[i] = ord_q[i-1];
					end
				end
			end
			LOP_POP: begin
				if (cnt_q != '0) begin
					cnt_d = cnt_m1;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		ord_q <= ord_d;
	end
endmodule

// ===== rtl/core/ttblc_chk.sv =====
// ----------------------------------------------------------------------------
// ttblc_chk
// Port-level checks of the cache's request and result sequencing.
// ----------------------------------------------------------------------------
module ttblc_chk (
	input logic            clk,
	input logic            arst_n,
	input logic            start,
	input logic            busy,
	input logic            res_valid,
	input ttblc_pkg::res_t res
);
	import ttblc_pkg::*;

	// A request accepted makes the block busy on the next cycle.
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but block not busy");

	// The final result of a request is shown as the block goes idle.
	a_fell_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> res_valid && res.last)
		else $error("block went idle without a final result");

	// A result that is not the final one comes while the request is still busy.
	a_mid_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res.last |-> busy)
		else $error("intermediate result outside a request");

	// No result of any kind comes directly after a final result.
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last |=> !res_valid)
		else $error("result directly after a final result");
endmodule

bind two_tier_budget_lru_cache ttblc_chk u_ttblc_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.res_valid (res_valid),
	.res       (res)
);
